>>> hw/rtl/class_priority_queue_core_defines.svh
// Assertion macros shared by the class priority queue checker.
`ifndef CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cpq_pkg.sv
// Types and constants shared by the class priority queue modules.
package cpq_pkg;
	localparam int CAPACITY = 16;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AGE_W = 7;
	localparam int TAG_W = 64;
	localparam int CLS_W = 3;
	localparam int OCC_W = 5;
	localparam int STATUS_W = 3;
	localparam int IN_TDATA_W = 72;
	localparam int OUT_TDATA_W = 72;
	localparam int CFG_IDX_W = 2;

	localparam logic [AGE_W-1:0] MIN_AGE_RST = 7'd18;
	localparam logic [AGE_W-1:0] MIDDLE_AGE_RST = 7'd45;
	localparam logic [AGE_W-1:0] SENIOR_AGE_RST = 7'd65;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED = 3'd0,
		ST_UNDERAGE = 3'd1,
		ST_FULL = 3'd2,
		ST_REMOVED = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_AGE = 2'd0,
		REG_MIDDLE_AGE = 2'd1,
		REG_SENIOR_AGE = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t ins;
	} cell_cmd_t;
endpackage

>>> hw/rtl/cpq_cell.sv
// One storage cell of the sorted queue, exchanging entries with its neighbors.
module cpq_cell (
	input  logic             clk,
	input  cpq_pkg::cell_cmd_t cmd,
	input  logic             occupied,
	input  logic             prev_keep,
	input  cpq_pkg::entry_t  prev_entry,
	input  cpq_pkg::entry_t  next_entry,
	output cpq_pkg::entry_t  entry,
	output logic             keep
);
	import cpq_pkg::*;

	entry_t entry_q;

	assign keep = occupied && (entry_q.cls >= cmd.ins.cls);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (!keep) begin
					entry_q <= prev_keep ? cmd.ins : prev_entry;
				end
			end
			OP_REMOVE: begin
				entry_q <= next_entry;
			end
			default: begin
			end
		endcase
	end
endmodule

>>> hw/rtl/class_priority_queue_core.sv
// Top level of the class priority queue: a sorted chain of cells with a result register.
//
// The slave stream carries one command per transaction: tuser selects enqueue or
// dequeue, tdata carries the age, health flag and tag of a new entry. Every accepted
// transaction produces exactly one result transaction on the master stream with a
// status code in tuser and the removed tag, class (or added class) and occupancy in tdata.
// The entries sit in a chain of cells kept sorted by class, highest at the head.
// An insert makes every cell compare its own class with the new one and either keep
// its entry, take the new one, or take its left neighbor's; a removal shifts all
// cells one place toward the head. The result is registered and appears in the
// cycle after the command is accepted, and one command can be accepted every cycle
// while the master side does not stall, so the sustained rate is one transaction per
// cycle. When the master side stalls, the result is held and no new command is
// accepted until it has been taken. Reset empties the queue and loads the default
// age thresholds. The configuration channel writes the three thresholds and is always
// ready; only write it while no command is in flight: the block does not enforce it.
module class_priority_queue_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0 up: age[6:0], health_flag[7], tag[71:8].
	input  logic [cpq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// Fields from bit 0 up: mode[0].
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0 up: tag_out[63:0], class_out[66:64], occupancy[71:67].
	output logic [cpq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// Fields from bit 0 up: status[2:0].
	output logic [cpq_pkg::STATUS_W-1:0]        m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cpq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cpq_pkg::AGE_W-1:0]           cfg_data
);
	import cpq_pkg::*;

	logic [AGE_W-1:0] min_age_q;
	logic [AGE_W-1:0] middle_age_q;
	logic [AGE_W-1:0] senior_age_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;

	logic out_valid_q;
	status_t status_q;
	logic [TAG_W-1:0] tag_out_q;
	logic [CLS_W-1:0] class_out_q;
	logic [OCC_W-1:0] occupancy_q;

	logic accept;
	logic [AGE_W-1:0] in_age;
	logic in_flag;
	logic [TAG_W-1:0] in_tag;
	logic [1:0] band;
	logic [CLS_W-1:0] in_cls;
	status_t status_next;
	cell_cmd_t cmd;

	entry_t cell_entry [CAPACITY];
	logic cell_keep [CAPACITY];
	logic cell_occupied [CAPACITY];

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	assign in_age = s_axis_tdata[AGE_W-1:0];
	assign in_flag = s_axis_tdata[AGE_W];
	assign in_tag = s_axis_tdata[AGE_W+TAG_W:AGE_W+1];

	always_comb begin
		if (in_age < middle_age_q) begin
			band = 2'd0;
		end else if (in_age < senior_age_q) begin
			band = 2'd1;
		end else begin
			band = 2'd2;
		end
		in_cls = {band, in_flag};
	end

	always_comb begin
		if (s_axis_tuser == MODE_ENQ) begin
			if (in_age < min_age_q) begin
				status_next = ST_UNDERAGE;
			end else if (count_q == CNT_W'(CAPACITY)) begin
				status_next = ST_FULL;
			end else begin
				status_next = ST_ADDED;
			end
		end else begin
			status_next = (count_q == '0) ? ST_EMPTY : ST_REMOVED;
		end
	end

	always_comb begin
		cmd.ins.cls = in_cls;
		cmd.ins.tag = in_tag;
		cmd.op = OP_HOLD;
		count_next = count_q;
		if (accept && status_next == ST_ADDED) begin
			cmd.op = OP_INSERT;
			count_next = count_q + CNT_W'(1);
		end else if (accept && status_next == ST_REMOVED) begin
			cmd.op = OP_REMOVE;
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		entry_t prev_entry;
		entry_t next_entry;
		logic prev_keep;

		assign cell_occupied[gi] = count_q > CNT_W'(gi);

		if (gi == 0) begin : g_head
			assign prev_keep = 1'b1;
			assign prev_entry = cmd.ins;
		end else begin : g_body
			assign prev_keep = cell_keep[gi-1];
			assign prev_entry = cell_entry[gi-1];
		end

		if (gi == CAPACITY - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_inner
			assign next_entry = cell_entry[gi+1];
		end

		cpq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occupied   (cell_occupied[gi]),
			.prev_keep  (prev_keep),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (cell_entry[gi]),
			.keep       (cell_keep[gi])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_age_q <= MIN_AGE_RST;
			middle_age_q <= MIDDLE_AGE_RST;
			senior_age_q <= SENIOR_AGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_AGE: min_age_q <= cfg_data;
				REG_MIDDLE_AGE: middle_age_q <= cfg_data;
				REG_SENIOR_AGE: senior_age_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_next;
			occupancy_q <= OCC_W'(count_next);
			case (status_next)
				ST_ADDED: begin
					tag_out_q <= '0;
					class_out_q <= in_cls;
				end
				ST_REMOVED: begin
					tag_out_q <= cell_entry[0].tag;
					class_out_q <= cell_entry[0].cls;
				end
				default: begin
					tag_out_q <= '0;
					class_out_q <= '0;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = status_q;
	assign m_axis_tdata = {occupancy_q, class_out_q, tag_out_q};
endmodule

>>> hw/rtl/cpq_checker.sv
// Port-level assertions for the class priority queue, bound to the top level.
`include "class_priority_queue_core_defines.svh"

module cpq_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [cpq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input logic [cpq_pkg::STATUS_W-1:0]        m_axis_tuser
);
	import cpq_pkg::*;

	`CPQ_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"Stalled result transaction changed.")

	`CPQ_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid,
		"Accepted command produced no result transaction.")

	`CPQ_ASSERT_SAME(a_ready_when_free, !m_axis_tvalid, s_axis_tready,
		"Command channel stalled while no result is pending.")

	`CPQ_ASSERT_SAME(a_full_occupancy, m_axis_tvalid && m_axis_tuser == ST_FULL,
		m_axis_tdata[OUT_TDATA_W-1:TAG_W+CLS_W] == OCC_W'(CAPACITY),
		"Full status reported with a queue that is not full.")

	`CPQ_ASSERT_SAME(a_empty_clean, m_axis_tvalid && m_axis_tuser == ST_EMPTY,
		m_axis_tdata == '0,
		"Empty status reported with nonzero tag, class or occupancy.")
endmodule

bind class_priority_queue_core cpq_checker u_cpq_checker (.*);
